@@ rtl/core/pc_return_stack_defines.svh @@
// assertion macros shared by the pc return stack modules
`ifndef PC_RETURN_STACK_DEFINES_SVH
`define PC_RETURN_STACK_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PRS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define PRS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/prs_pkg.sv @@
// shared types and constants of the pc return stack
`default_nettype none

package prs_pkg;

    localparam int unsigned DEF_STACK_DEPTH = 8;
    localparam int unsigned DEF_PC_WIDTH    = 16;
    localparam int unsigned KIND_W          = 3;
    localparam int unsigned PC_IO_W         = 16;
    localparam int unsigned PC_MAX_W        = 32;

    // operation codes carried in the input tuser
    typedef enum logic [KIND_W-1:0] {
        KIND_ADVANCE = KIND_W'(0),
        KIND_JUMP    = KIND_W'(1),
        KIND_CALL    = KIND_W'(2),
        KIND_RETURN  = KIND_W'(3),
        KIND_CLEAR   = KIND_W'(4)
    } kind_t;

    // one accepted operation
    typedef struct packed {
        kind_t               kind;
        logic [PC_IO_W-1:0]  pc_in;
    } op_t;

    // one result transaction
    typedef struct packed {
        logic [PC_IO_W-1:0]  pc_out;
        logic                fault;
    } result_t;

endpackage

`default_nettype wire

@@ rtl/core/prs_stack.sv @@
// stack engine: top entries in registers, deeper entries in a memory
`default_nettype none
`include "pc_return_stack_defines.svh"

module prs_stack
    import prs_pkg::*;
#(
    parameter int unsigned STACK_DEPTH = DEF_STACK_DEPTH,
    parameter int unsigned PC_WIDTH    = DEF_PC_WIDTH
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    accept,
    input  wire op_t     op,
    output result_t      result
);

    localparam int unsigned SP_W = $clog2(STACK_DEPTH);
    localparam logic [SP_W-1:0] SP_MAX = SP_W'(STACK_DEPTH - 1);

    // pointer and cached top three entries
    logic [SP_W-1:0]        sp_reg, sp_next;
    logic [PC_WIDTH-1:0]    tos_reg, tos_next;
    logic [PC_WIDTH-1:0]    nos_reg, nos_next;
    logic [PC_WIDTH-1:0]    pre_reg, pre_next;

    // deeper entries and their valid bits
    logic [PC_WIDTH-1:0]    mem [STACK_DEPTH];
    logic [PC_WIDTH-1:0]    rd_data_reg;
    logic                   rd_valid_reg, rd_valid_next;
    logic [STACK_DEPTH-1:0] valid_reg, valid_next;

    logic                   wr_en;
    logic [SP_W-1:0]        wr_addr;
    logic [SP_W-1:0]        rd_addr;
    logic [SP_W:0]          sp_ext;
    logic                   clear;
    logic                   fault;
    logic [PC_WIDTH-1:0]    target;
    logic [PC_WIDTH-1:0]    rd_entry;
    logic [PC_MAX_W-1:0]    wide_in;
    logic [PC_MAX_W-1:0]    wide_out;

    // target reduced to the entry width
    assign wide_in  = PC_MAX_W'(op.pc_in);
    assign target   = wide_in[PC_WIDTH-1:0];

    // entry three below the top, zero when cleared
    assign rd_entry = rd_valid_reg ? rd_data_reg : '0;

    // operation decode and next state
    always_comb
    begin
        sp_next    = sp_reg;
        tos_next   = tos_reg;
        nos_next   = nos_reg;
        pre_next   = pre_reg;
        valid_next = valid_reg;
        wr_en      = 1'b0;
        wr_addr    = sp_reg - SP_W'(1);
        fault      = 1'b0;
        clear      = 1'b0;
        if (accept)
        begin
            case (op.kind)
                KIND_ADVANCE:
                begin
                    tos_next = tos_reg + PC_WIDTH'(1);
                end
                KIND_JUMP:
                begin
                    tos_next = target;
                end
                KIND_CALL:
                begin
                    if (sp_reg == SP_MAX)
                    begin
                        fault = 1'b1;
                    end
                    else
                    begin
                        sp_next  = sp_reg + SP_W'(1);
                        tos_next = target;
                        nos_next = tos_reg;
                        pre_next = nos_reg;
                        // spill the old second entry into the memory
                        if (sp_reg != '0)
                        begin
                            wr_en               = 1'b1;
                            valid_next[wr_addr] = 1'b1;
                        end
                    end
                end
                KIND_RETURN:
                begin
                    if (sp_reg == '0)
                    begin
                        fault = 1'b1;
                    end
                    else
                    begin
                        sp_next  = sp_reg - SP_W'(1);
                        tos_next = nos_reg + PC_WIDTH'(1);
                        nos_next = pre_reg;
                        pre_next = rd_entry;
                    end
                end
                KIND_CLEAR:
                begin
                    tos_next   = '0;
                    nos_next   = '0;
                    pre_next   = '0;
                    valid_next = '0;
                    clear      = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    // prefetch the entry three below the next top
    assign sp_ext  = {1'b0, sp_next};
    assign rd_addr = (sp_ext >= (SP_W + 1)'(3)) ? SP_W'(sp_ext - (SP_W + 1)'(3)) : '0;
    assign rd_valid_next = valid_reg[rd_addr] && !clear;

    // result of this operation
    assign wide_out      = PC_MAX_W'(tos_next);
    assign result.pc_out = wide_out[PC_IO_W-1:0];
    assign result.fault  = fault;

    // control and cached entries
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg       <= '0;
            tos_reg      <= '0;
            nos_reg      <= '0;
            pre_reg      <= '0;
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            sp_reg       <= sp_next;
            tos_reg      <= tos_next;
            nos_reg      <= nos_next;
            pre_reg      <= pre_next;
            valid_reg    <= valid_next;
            rd_valid_reg <= rd_valid_next;
        end
    end

    // entry memory, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= nos_reg;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // a call below the limit moves the pointer up and keeps the old top beneath
    `PRS_ASSERT_NEXT(a_call_push, accept && op.kind == KIND_CALL && sp_reg != SP_MAX,
        sp_reg == $past(sp_reg) + SP_W'(1) && nos_reg == $past(tos_reg),
        "call did not push")

    // a faulting operation leaves the stack untouched
    `PRS_ASSERT_NEXT(a_fault_hold, accept && fault,
        $stable(sp_reg) && $stable(tos_reg) && $stable(nos_reg) && $stable(pre_reg),
        "faulting operation changed the stack")

    // the pointer never leaves the stack
    `PRS_ASSERT_NOW(a_sp_range, 1'b1, sp_reg <= SP_MAX, "stack pointer out of range")

endmodule

`default_nettype wire

@@ rtl/core/prs_skid.sv @@
// two-entry output buffer that decouples the result side from the input side
`default_nettype none
`include "pc_return_stack_defines.svh"

module prs_skid
    import prs_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire result_t  in_data,
    output logic          out_valid,
    input  wire logic     out_ready,
    output result_t       out_data
);

    logic    main_valid_reg, main_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t main_reg, main_next;
    result_t skid_reg, skid_next;
    logic    push;
    logic    pop;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;
    assign push      = in_valid && in_ready;
    assign pop       = main_valid_reg && out_ready;

    // buffer fill and drain
    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_valid_next = push;
                main_next       = in_data;
            end
        end
        else if (push)
        begin
            if (!main_valid_reg)
            begin
                main_valid_next = 1'b1;
                main_next       = in_data;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_next       = in_data;
            end
        end
    end

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    // the skid entry is only used behind a full main entry
    `PRS_ASSERT_NOW(a_skid_order, skid_valid_reg, main_valid_reg, "skid entry without main entry")

    // a transaction arriving at a stalled full main entry lands in the skid entry
    `PRS_ASSERT_NEXT(a_skid_fill, push && main_valid_reg && !out_ready,
        skid_valid_reg && skid_reg == $past(in_data), "stalled transaction lost")

    // draining with a held skid entry moves it forward
    `PRS_ASSERT_NEXT(a_skid_drain, pop && skid_valid_reg,
        main_valid_reg && !skid_valid_reg && main_reg == $past(skid_reg),
        "skid entry not moved forward")

endmodule

`default_nettype wire

@@ rtl/core/pc_return_stack.sv @@
// Program-counter return stack of STACK_DEPTH entries of PC_WIDTH bits. Each input
// transaction carries one operation in s_axis_tuser (advance, jump, call, return,
// clear) and a target in s_axis_tdata; each produces exactly one result transaction
// with the new top entry and a fault flag for a call on a full stack or a return on
// an empty one, which leave the stack unchanged. One operation is taken every clock
// cycle while the output buffer has room; the stack state updates through the top three
// entries held in registers, with deeper entries in a one-write, one-read memory whose
// next needed entry is prefetched. The result is registered into a two-entry output
// buffer on acceptance, so input stalls only when both buffer entries are held.
`default_nettype none

module pc_return_stack
    import prs_pkg::*;
#(
    parameter int unsigned STACK_DEPTH = DEF_STACK_DEPTH,
    parameter int unsigned PC_WIDTH    = DEF_PC_WIDTH
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    input  wire logic [PC_IO_W-1:0]  s_axis_tdata,   // pc_in
    input  wire logic [KIND_W-1:0]   s_axis_tuser,   // kind
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    output logic [PC_IO_W-1:0]       m_axis_tdata,   // pc_out
    output logic                     m_axis_tuser    // fault
);

    logic    accept;
    logic    buf_ready;
    op_t     op;
    result_t result;
    result_t out_data;

    // input transaction
    assign accept        = s_axis_tvalid && buf_ready;
    assign s_axis_tready = buf_ready;
    assign op.kind       = kind_t'(s_axis_tuser);
    assign op.pc_in      = s_axis_tdata;

    // stack engine
    prs_stack #(
        .STACK_DEPTH (STACK_DEPTH),
        .PC_WIDTH    (PC_WIDTH)
    ) u_stack (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .op     (op),
        .result (result)
    );

    // result buffer
    prs_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .in_ready  (buf_ready),
        .in_data   (result),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_data)
    );

    assign m_axis_tdata = out_data.pc_out;
    assign m_axis_tuser = out_data.fault;

endmodule

`default_nettype wire
